// ===== rtl/core/lcps_pkg.sv =====
// Shared types, constants and fixed-point helpers for the line centroid PID steering block.
// No dependencies; all other files but the port checks refer to it by scoped names.
package lcps_pkg;

  localparam int SUM_W = 19;        // offset accumulator, signed
  localparam int CNT_W = 11;        // white pixel counter, unsigned
  localparam int PROD_W = 44;       // shared product register
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QFILL_W = 2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 19'sh3FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 19'sh40000;
  localparam logic [CNT_W-1:0] COUNT_MAX = 11'h7FF;
  localparam logic [9:0] MEAN_MAX = 10'd1023;

  localparam logic signed [25:0] HALF_SPAN = 26'sd160;
  localparam logic signed [25:0] SLOPE_OUTER = 26'sd200;
  localparam logic signed [25:0] SLOPE_INNER = 26'sd250;
  localparam logic [25:0] SAT_LIMIT = 26'd40960;    // 256 * 160
  localparam logic [11:0] RECIP5 = 12'd3277;        // ~16384/5, exact floor for x < 1280

  // Register indexes of the configuration port
  localparam logic [2:0] REG_WHITE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_CENTER_COLUMN = 3'd1;
  localparam logic [2:0] REG_PROP_GAIN = 3'd2;
  localparam logic [2:0] REG_DERIV_GAIN = 3'd3;
  localparam logic [2:0] REG_INTEG_GAIN = 3'd4;
  localparam logic [2:0] REG_BASE_SPEED = 3'd5;
  localparam logic [2:0] REG_SPIN_SPEED = 3'd6;

  typedef struct packed {
    logic [7:0] white_threshold;
    logic [9:0] center_column;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [15:0] integ_gain;
    logic signed [8:0] base_speed;
    logic [7:0] spin_speed;
  } cfg_t;

  // One closed frame handed from front to back
  typedef struct packed {
    logic signed [SUM_W-1:0] offset_sum;
    logic [CNT_W-1:0] white_count;
  } frame_t;

  // Q4.12 scaling, truncated toward zero
  function automatic logic signed [PROD_W-1:0] q12_div(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] r;
    if (x[PROD_W-1]) begin
      r = -((-x) >>> 12);
    end else begin
      r = x >>> 12;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] x);
    logic signed [15:0] r;
    if (x > 44'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -44'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  // trunc(n / 160) saturated to -255..255; /160 = >>5 then reciprocal of 5
  function automatic logic signed [8:0] div160_sat(input logic signed [25:0] n);
    logic neg;
    logic [25:0] mag;
    logic [10:0] x;
    logic [22:0] prod;
    logic [7:0] q;
    neg = n[25];
    mag = neg ? 26'(-n) : 26'(n);
    x = mag[15:5];
    prod = 23'(x) * 23'(RECIP5);
    if (mag >= SAT_LIMIT) begin
      q = 8'hFF;
    end else begin
      q = prod[21:14];
    end
    return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

// ===== rtl/core/lcps_front.sv =====
// Pixel front end: classifies each pixel against the threshold and accumulates the frame.
// Depends on lcps_pkg; hands closed frames to lcps_queue.
module lcps_front (
  input  logic clk,
  input  logic rst,
  input  lcps_pkg::cfg_t cfg,
  input  logic pix_valid,
  output logic pix_ready,
  input  logic [7:0] pixel_level,
  input  logic [9:0] column,
  input  logic frame_end,
  input  logic q_full,
  output logic push,
  output lcps_pkg::frame_t push_data
);

  logic signed [lcps_pkg::SUM_W-1:0] offset_sum, offset_sum_next;
  logic [lcps_pkg::CNT_W-1:0] white_count, white_count_next;
  logic signed [10:0] diff;
  logic signed [lcps_pkg::SUM_W:0] sum_wide;
  logic is_white, accept;

  assign pix_ready = !q_full;
  assign accept = pix_valid && pix_ready;
  assign is_white = pixel_level > cfg.white_threshold;
  assign diff = $signed({1'b0, column}) - $signed({1'b0, cfg.center_column});
  assign sum_wide = {offset_sum[lcps_pkg::SUM_W-1], offset_sum} + 20'(diff);

  always_comb begin
    offset_sum_next = offset_sum;
    white_count_next = white_count;
    if (is_white) begin
      if (sum_wide > 20'(lcps_pkg::SUM_MAX)) begin
        offset_sum_next = lcps_pkg::SUM_MAX;
      end else if (sum_wide < 20'(lcps_pkg::SUM_MIN)) begin
        offset_sum_next = lcps_pkg::SUM_MIN;
      end else begin
        offset_sum_next = sum_wide[lcps_pkg::SUM_W-1:0];
      end
      if (white_count != lcps_pkg::COUNT_MAX) begin
        white_count_next = white_count + 1'b1;
      end
    end
  end

  assign push = accept && frame_end;
  assign push_data = '{offset_sum: offset_sum_next, white_count: white_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_sum <= '0;
      white_count <= '0;
    end else if (accept) begin
      if (frame_end) begin
        offset_sum <= '0;
        white_count <= '0;
      end else begin
        offset_sum <= offset_sum_next;
        white_count <= white_count_next;
      end
    end
  end

endmodule

// ===== rtl/core/lcps_queue.sv =====
// Two-entry frame queue between the pixel front end and the PID back end.
// Depends on lcps_pkg for frame_t and depth constants.
module lcps_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  lcps_pkg::frame_t push_data,
  output logic full,
  output logic valid,
  output lcps_pkg::frame_t data,
  input  logic pop
);

  lcps_pkg::frame_t mem [lcps_pkg::QUEUE_DEPTH];
  logic [lcps_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [lcps_pkg::QFILL_W-1:0] fill;

  assign full = fill == lcps_pkg::QFILL_W'(lcps_pkg::QUEUE_DEPTH);
  assign valid = fill != '0;
  assign data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10: fill <= fill + 1'b1;
        2'b01: fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/lcps_back.sv =====
// Frame back end: bit-serial mean division, PID on a shared multiplier, wheel mixing.
// Depends on lcps_pkg; owns the PID state and the result register.
module lcps_back (
  input  logic clk,
  input  logic rst,
  input  lcps_pkg::cfg_t cfg,
  input  logic q_valid,
  input  lcps_pkg::frame_t q_data,
  output logic pop,
  output logic res_valid,
  input  logic res_ready,
  output logic signed [8:0] left_speed,
  output logic signed [8:0] right_speed,
  output logic line_found,
  output logic signed [10:0] mean_offset,
  output logic signed [15:0] control_sum,
  output logic [15:0] white_pixels
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MEAN, S_PMUL, S_P, S_D, S_DQ, S_IMUL, S_IQ, S_SUM, S_WMUL, S_WDIV
  } state_t;

  state_t state;

  // frame in work
  logic sum_neg, found;
  logic [lcps_pkg::CNT_W-1:0] count;
  logic [lcps_pkg::SUM_W-1:0] dvd;          // dividend, becomes quotient
  logic [lcps_pkg::CNT_W-1:0] rem;
  logic [4:0] step;

  // PID state and temporaries
  logic signed [15:0] previous_error;
  logic signed [23:0] error_integral;
  logic signed [10:0] mean;
  logic signed [15:0] p_val;
  logic signed [21:0] d_val;
  logic signed [28:0] i_val;
  logic signed [15:0] ctl;
  logic spin_left_neg;
  logic signed [lcps_pkg::PROD_W-1:0] prod;
  logic signed [25:0] num_l, num_r;

  logic [lcps_pkg::CNT_W:0] rem_shift;
  logic rem_ge;
  logic signed [lcps_pkg::PROD_W-1:0] scaled;
  logic signed [16:0] err_diff;
  logic signed [24:0] integ_wide;
  logic signed [31:0] pid_wide;
  logic signed [25:0] slope_l, slope_r;
  logic [lcps_pkg::SUM_W-1:0] q_mag;
  logic [9:0] q_clamped;
  logic slot_free;
  logic signed [8:0] spin;

  assign rem_shift = {rem, dvd[lcps_pkg::SUM_W-1]};
  assign rem_ge = rem_shift >= {1'b0, count};
  assign scaled = lcps_pkg::q12_div(prod);
  assign err_diff = 17'(p_val) - 17'(previous_error);
  assign integ_wide = 25'(error_integral) + 25'(p_val);
  assign pid_wide = 32'(p_val) + 32'(d_val) + 32'(i_val);
  assign slope_l = (ctl > 16'sd0) ? lcps_pkg::SLOPE_OUTER : lcps_pkg::SLOPE_INNER;
  assign slope_r = (ctl > 16'sd0) ? lcps_pkg::SLOPE_INNER : lcps_pkg::SLOPE_OUTER;
  assign q_mag = dvd;
  assign q_clamped = (q_mag > lcps_pkg::SUM_W'(lcps_pkg::MEAN_MAX)) ? lcps_pkg::MEAN_MAX
                                                                      : q_mag[9:0];
  assign slot_free = !res_valid || res_ready;
  assign spin = $signed({1'b0, cfg.spin_speed});
  assign pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      previous_error <= '0;
      error_integral <= '0;
      step <= '0;
    end else begin
      // the last step reloads the result register itself when it frees
      if (res_valid && res_ready && state != S_WDIV) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            sum_neg <= q_data.offset_sum[lcps_pkg::SUM_W-1];
            dvd <= q_data.offset_sum[lcps_pkg::SUM_W-1] ? lcps_pkg::SUM_W'(-q_data.offset_sum)
                                                         : q_data.offset_sum;
            count <= q_data.white_count;
            found <= q_data.white_count != '0;
            rem <= '0;
            step <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (rem_ge) begin
            rem <= lcps_pkg::CNT_W'(rem_shift - {1'b0, count});
          end else begin
            rem <= rem_shift[lcps_pkg::CNT_W-1:0];
          end
          dvd <= {dvd[lcps_pkg::SUM_W-2:0], rem_ge};
          step <= step + 1'b1;
          if (step == 5'(lcps_pkg::SUM_W - 1)) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (!found) begin
            mean <= '0;
          end else if (sum_neg) begin
            mean <= -$signed({1'b0, q_clamped});
          end else begin
            mean <= $signed({1'b0, q_clamped});
          end
          state <= S_PMUL;
        end
        S_PMUL: begin
          prod <= lcps_pkg::PROD_W'(mean * $signed({1'b0, cfg.prop_gain}));
          state <= S_P;
        end
        S_P: begin
          p_val <= lcps_pkg::sat16(scaled);
          state <= S_D;
        end
        S_D: begin
          prod <= lcps_pkg::PROD_W'(err_diff * $signed({1'b0, cfg.deriv_gain}));
          spin_left_neg <= previous_error > 16'sd0;
          previous_error <= p_val;
          if (integ_wide > 25'sh07FFFFF) begin
            error_integral <= 24'sh7FFFFF;
          end else if (integ_wide < -25'sh0800000) begin
            error_integral <= 24'sh800000;
          end else begin
            error_integral <= integ_wide[23:0];
          end
          state <= S_DQ;
        end
        S_DQ: begin
          d_val <= scaled[21:0];
          state <= S_IMUL;
        end
        S_IMUL: begin
          prod <= lcps_pkg::PROD_W'(error_integral * $signed({1'b0, cfg.integ_gain}));
          state <= S_IQ;
        end
        S_IQ: begin
          i_val <= scaled[28:0];
          state <= S_SUM;
        end
        S_SUM: begin
          ctl <= lcps_pkg::sat16(lcps_pkg::PROD_W'(pid_wide));
          state <= S_WMUL;
        end
        S_WMUL: begin
          num_l <= 26'(cfg.base_speed) * lcps_pkg::HALF_SPAN + 26'(ctl) * slope_l;
          num_r <= 26'(cfg.base_speed) * lcps_pkg::HALF_SPAN - 26'(ctl) * slope_r;
          state <= S_WDIV;
        end
        S_WDIV: begin
          if (slot_free) begin
            if (found) begin
              left_speed <= lcps_pkg::div160_sat(num_l);
              right_speed <= lcps_pkg::div160_sat(num_r);
            end else begin
              left_speed <= spin_left_neg ? -spin : spin;
              right_speed <= spin_left_neg ? spin : -spin;
            end
            line_found <= found;
            mean_offset <= mean;
            control_sum <= ctl;
            white_pixels <= 16'(count);
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/line_centroid_pid_steering.sv =====
// Top level of the line centroid PID steering block: configuration registers and wiring.
// Depends on lcps_pkg, lcps_front, lcps_queue and lcps_back.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------------
//   pixel in | pix_valid / pix_ready | pixel_level, column, frame_end
//   result   | res_valid / res_ready | left_speed, right_speed, line_found,
//            |                       | mean_offset, control_sum, white_pixels
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Pixels go in one per cycle while pix_ready is high; a result comes per closed frame.
// The back end takes each frame from the queue, finds the mean by bit-serial
// division, then runs ten steps for P, D, I on one shared multiplier and the wheel
// mix, the last of which loads the result register; a stalled result holds the
// back end in its last step.
// Two closed frames may wait in the queue; pix_ready drops only while both slots are full.
// Synchronous reset restores register defaults and clears accumulators and PID state.
// cfg_ready is always high; writes to unused indexes are dropped.
module line_centroid_pid_steering (
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_ready,
  input  logic [7:0] pixel_level,
  input  logic [9:0] column,
  input  logic frame_end,
  output logic res_valid,
  input  logic res_ready,
  output logic signed [8:0] left_speed,
  output logic signed [8:0] right_speed,
  output logic line_found,
  output logic signed [10:0] mean_offset,
  output logic signed [15:0] control_sum,
  output logic [15:0] white_pixels,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  lcps_pkg::cfg_t cfg;
  lcps_pkg::frame_t push_data, q_data;
  logic push, pop, q_full, q_valid;

  assign cfg_ready = 1'b1;

  // Register file; writes are expected only while the block is idle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.white_threshold <= 8'd128;
      cfg.center_column <= 10'd160;
      cfg.prop_gain <= 16'd614;
      cfg.deriv_gain <= 16'd4096;
      cfg.integ_gain <= 16'd0;
      cfg.base_speed <= 9'sd60;
      cfg.spin_speed <= 8'd50;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lcps_pkg::REG_WHITE_THRESHOLD: cfg.white_threshold <= cfg_data[7:0];
        lcps_pkg::REG_CENTER_COLUMN: cfg.center_column <= cfg_data[9:0];
        lcps_pkg::REG_PROP_GAIN: cfg.prop_gain <= cfg_data;
        lcps_pkg::REG_DERIV_GAIN: cfg.deriv_gain <= cfg_data;
        lcps_pkg::REG_INTEG_GAIN: cfg.integ_gain <= cfg_data;
        lcps_pkg::REG_BASE_SPEED: cfg.base_speed <= $signed(cfg_data[8:0]);
        lcps_pkg::REG_SPIN_SPEED: cfg.spin_speed <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Front: per-pixel threshold and accumulation
  lcps_front u_front (
    .clk, .rst, .cfg,
    .pix_valid, .pix_ready, .pixel_level, .column, .frame_end,
    .q_full, .push, .push_data
  );

  // Closed frames wait here while the back end is busy
  lcps_queue u_queue (
    .clk, .rst, .push, .push_data,
    .full(q_full), .valid(q_valid), .data(q_data), .pop
  );

  // Back: mean, PID and wheel speeds, result register
  lcps_back u_back (
    .clk, .rst, .cfg,
    .q_valid, .q_data, .pop,
    .res_valid, .res_ready,
    .left_speed, .right_speed, .line_found, .mean_offset, .control_sum, .white_pixels
  );

endmodule

// ===== rtl/core/lcps_checker.sv =====
// Port-level checks for line_centroid_pid_steering, attached with a bind.
// Depends only on the top level's ports.
module lcps_port_checks (
  input logic clk,
  input logic rst,
  input logic cfg_ready,
  input logic res_valid,
  input logic res_ready,
  input logic signed [8:0] left_speed,
  input logic signed [8:0] right_speed,
  input logic line_found,
  input logic signed [10:0] mean_offset,
  input logic [15:0] white_pixels
);

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(left_speed) && $stable(right_speed)
      && $stable(line_found) && $stable(white_pixels))
    else $error("result changed while stalled");

  // Line flag agrees with the pixel count
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (line_found == (white_pixels != 16'd0)))
    else $error("line_found disagrees with white_pixels");

  // Lost line: zero offset and a pure spin
  a_spin: assert property (@(posedge clk) disable iff (rst)
    res_valid && !line_found |-> mean_offset == 11'sd0 && left_speed == -right_speed)
    else $error("lost-line result is not a spin");

  // Wheel saturation never reaches -256
  a_wheel_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> left_speed != -9'sd256 && right_speed != -9'sd256)
    else $error("wheel speed out of range");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind line_centroid_pid_steering lcps_port_checks u_lcps_port_checks (
  .clk, .rst, .cfg_ready, .res_valid, .res_ready, .left_speed, .right_speed,
  .line_found, .mean_offset, .white_pixels
);

// ===== tb/lcps_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for line_centroid_pid_steering: watches the pixel, result and register channels.
// Predicts each frame's steering command and compares it; depends on lcps_pkg for indexes.
module lcps_checker (
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  input  logic pix_ready,
  input  logic [7:0] pixel_level,
  input  logic [9:0] column,
  input  logic frame_end,
  input  logic res_valid,
  input  logic res_ready,
  input  logic signed [8:0] left_speed,
  input  logic signed [8:0] right_speed,
  input  logic line_found,
  input  logic signed [10:0] mean_offset,
  input  logic signed [15:0] control_sum,
  input  logic [15:0] white_pixels,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int fail_count,
  output int pending,
  output int results_seen,
  output int lost_results
);

  typedef struct packed {
    logic signed [8:0] left;
    logic signed [8:0] right;
    logic found;
    logic signed [10:0] mean;
    logic signed [15:0] ctl;
    logic [15:0] whites;
  } steer_cmd_t;

  // register shadow
  int thr_lvl, ctr_col, kp, kd, ki, base_spd, spin_spd;
  // frame accumulators and PID state
  longint acc_sum, acc_count, last_p, integ_acc;

  steer_cmd_t steer_due[$];

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
    lost_results = 0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void set_register(logic [2:0] idx, logic [15:0] data);
    case (idx)
      lcps_pkg::REG_WHITE_THRESHOLD: thr_lvl = int'(data[7:0]);
      lcps_pkg::REG_CENTER_COLUMN: ctr_col = int'(data[9:0]);
      lcps_pkg::REG_PROP_GAIN: kp = int'(data);
      lcps_pkg::REG_DERIV_GAIN: kd = int'(data);
      lcps_pkg::REG_INTEG_GAIN: ki = int'(data);
      lcps_pkg::REG_BASE_SPEED: base_spd = int'($signed(data[8:0]));
      lcps_pkg::REG_SPIN_SPEED: spin_spd = int'(data[7:0]);
      default: ;
    endcase
  endfunction

  function automatic void add_pixel(logic [7:0] lvl, logic [9:0] col);
    if (int'(lvl) > thr_lvl) begin
      acc_sum = clip(acc_sum + longint'(col) - ctr_col, -262144, 262143);
      if (acc_count < 2047) acc_count++;
    end
  endfunction

  // Mean offset, PID and wheel mix for the frame just closed; clears the accumulators.
  function automatic steer_cmd_t close_frame_steering();
    steer_cmd_t c;
    longint mean, p, d, i, ctl, lw, rw, sl, sr, prior;
    bit seen;
    prior = last_p;
    seen = acc_count > 0;
    mean = seen ? clip(acc_sum / acc_count, -1023, 1023) : 0;
    p = clip((mean * kp) / 4096, -32768, 32767);
    d = ((p - prior) * kd) / 4096;
    last_p = p;
    integ_acc = clip(integ_acc + p, -8388608, 8388607);
    i = (integ_acc * ki) / 4096;
    ctl = clip(p + d + i, -32768, 32767);
    if (!seen) begin
      // lost line: spin toward the side of the error before this frame
      lw = prior > 0 ? -spin_spd : spin_spd;
      rw = -lw;
    end else begin
      sl = ctl > 0 ? 200 : 250;
      sr = ctl > 0 ? 250 : 200;
      lw = (longint'(base_spd) * 160 + ctl * sl) / 160;
      rw = (longint'(base_spd) * 160 - ctl * sr) / 160;
    end
    c.left = 9'(clip(lw, -255, 255));
    c.right = 9'(clip(rw, -255, 255));
    c.found = seen;
    c.mean = 11'(mean);
    c.ctl = 16'(ctl);
    c.whites = 16'(acc_count);
    acc_sum = 0;
    acc_count = 0;
    return c;
  endfunction

  always @(posedge clk) begin
    steer_cmd_t got, want;
    if (rst) begin
      thr_lvl = 128;
      ctr_col = 160;
      kp = 614;
      kd = 4096;
      ki = 0;
      base_spd = 60;
      spin_spd = 50;
      acc_sum = 0;
      acc_count = 0;
      last_p = 0;
      integ_acc = 0;
      steer_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) set_register(cfg_index, cfg_data);
      if (pix_valid && pix_ready) begin
        add_pixel(pixel_level, column);
        if (frame_end) steer_due.push_back(close_frame_steering());
      end
      if (res_valid && res_ready) begin
        got.left = left_speed;
        got.right = right_speed;
        got.found = line_found;
        got.mean = mean_offset;
        got.ctl = control_sum;
        got.whites = white_pixels;
        results_seen++;
        if (!line_found) lost_results++;
        if (steer_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: steering item with no frame outstanding", $realtime);
        end else begin
          want = steer_due.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.found !== want.found || got.mean !== want.mean ||
              got.ctl !== want.ctl || got.whites !== want.whites) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("%0t: steering mismatch (exp/got) left %0d/%0d right %0d/%0d ",
                     $realtime, $signed(want.left), $signed(got.left),
                     $signed(want.right), $signed(got.right));
              $display("found %0d/%0d mean %0d/%0d ctl %0d/%0d whites %0d/%0d",
                       want.found, got.found, $signed(want.mean), $signed(got.mean),
                       $signed(want.ctl), $signed(got.ctl), want.whites, got.whites);
            end
          end
        end
      end
    end
    pending <= steer_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the line_centroid_pid_steering testbench: clock, reset, pixel and register stimulus.
// Depends on lcps_pkg, the block itself and lcps_checker, which does all predicting.
module tb_top;

  localparam int PIXEL_GOAL = 120;     // random pixel items over all phases
  localparam int PHASES = 10;
  localparam int SAT_RUN = 260;        // 260 * 1023 is past the offset sum's range
  localparam int DRAIN_CYCLES = 64;    // drain time for the back end; two frames can queue
  localparam logic [2:0] REG_NONE = 3'd7;  // unused index, writes must be dropped

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_ready;
  logic [7:0] pixel_level = '0;
  logic [9:0] column = '0;
  logic frame_end = 1'b0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic signed [8:0] left_speed, right_speed;
  logic line_found;
  logic signed [10:0] mean_offset;
  logic signed [15:0] control_sum;
  logic [15:0] white_pixels;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int fail_count, pending, results_seen, lost_results;

  // stimulus-side copy of the two registers that shape pixel content
  int cur_thr = 128;
  int cur_ctr = 160;
  int pixels_sent = 0;
  int writes_done = 0;
  bit pix_gaps_on = 1'b1;
  bit res_stalls_on = 1'b1;

  line_centroid_pid_steering dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_ready(pix_ready),
    .pixel_level(pixel_level), .column(column), .frame_end(frame_end),
    .res_valid(res_valid), .res_ready(res_ready),
    .left_speed(left_speed), .right_speed(right_speed), .line_found(line_found),
    .mean_offset(mean_offset), .control_sum(control_sum), .white_pixels(white_pixels),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lcps_checker u_checker (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_ready(pix_ready),
    .pixel_level(pixel_level), .column(column), .frame_end(frame_end),
    .res_valid(res_valid), .res_ready(res_ready),
    .left_speed(left_speed), .right_speed(right_speed), .line_found(line_found),
    .mean_offset(mean_offset), .control_sum(control_sum), .white_pixels(white_pixels),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .results_seen(results_seen), .lost_results(lost_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (long stalls on every item and frame).
  initial begin
    #5_000_000;
    $display("timeout: block stopped making progress");
    $display("status: fail");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Result side: ready drops for random stretches while stalls are enabled.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        res_ready <= 1'b0;
        hold--;
      end else begin
        res_ready <= 1'b1;
        if (res_stalls_on) hold = pick_gap();
      end
    end
  end

  // One pixel item. Valid only drops when a gap is taken, so back-to-back items keep it high.
  // Ready is read right after the edge, before the block's registers move.
  task automatic send_pixel(input logic [7:0] lvl, input logic [9:0] col, input logic eof);
    int gap;
    gap = pix_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid <= 1'b1;
    pixel_level <= lvl;
    column <= col;
    frame_end <= eof;
    do @(posedge clk); while (!pix_ready);
    pixels_sent++;
  endtask

  // Idle point: all frames answered, then let the back end run dry.
  task automatic settle();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    writes_done++;
    if (idx == lcps_pkg::REG_WHITE_THRESHOLD) cur_thr = int'(data[7:0]);
    if (idx == lcps_pkg::REG_CENTER_COLUMN) cur_ctr = int'(data[9:0]);
  endtask

  // Full register set; bits above a narrow register's width carry junk that must be ignored.
  task automatic load_settings(input int thr, input int ctr, input int p_gain, input int d_gain,
                               input int i_gain, input int base, input int spin);
    settle();
    write_reg(lcps_pkg::REG_WHITE_THRESHOLD, {8'($urandom), 8'(thr)});
    write_reg(lcps_pkg::REG_CENTER_COLUMN, {6'($urandom), 10'(ctr)});
    write_reg(lcps_pkg::REG_PROP_GAIN, 16'(p_gain));
    write_reg(lcps_pkg::REG_DERIV_GAIN, 16'(d_gain));
    write_reg(lcps_pkg::REG_INTEG_GAIN, 16'(i_gain));
    write_reg(lcps_pkg::REG_BASE_SPEED, {7'($urandom), 9'(base)});
    write_reg(lcps_pkg::REG_SPIN_SPEED, {8'($urandom), 8'(spin)});
  endtask

  // Long bright run at one column: drives the offset sum to saturation.
  task automatic send_bright_run(input int n, input int col);
    for (int k = 1; k <= n; k++)
      send_pixel(8'd255, 10'(col), k == n);
  endtask

  // Random frame: length mostly short, line density picked per frame (some frames see nothing).
  task automatic send_random_frame();
    int len, r, white_pct, lvl, col;
    bit is_white;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(1, 8);
    else if (r < 92) len = $urandom_range(9, 30);
    else len = $urandom_range(31, 120);
    white_pct = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 100);
    for (int k = 1; k <= len; k++) begin
      is_white = $urandom_range(1, 100) <= white_pct;
      if (is_white && cur_thr < 255) lvl = $urandom_range(cur_thr + 1, 255);
      else if (!is_white) lvl = $urandom_range(0, cur_thr);
      else lvl = $urandom_range(0, 255);
      // half the columns near the center so the loop is not always saturated
      if ($urandom_range(0, 1)) begin
        col = $urandom_range(0, 1023);
      end else begin
        col = cur_ctr + $urandom_range(0, 160) - 80;
        col = col < 0 ? 0 : (col > 1023 ? 1023 : col);
      end
      send_pixel(8'(lvl), 10'(col), k == len);
    end
  endtask

  initial begin
    int phase_start;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames at reset settings (threshold 128, center 160).
    send_pixel(8'd255, 10'd1023, 1'b1);   // far right, wheels saturate
    send_pixel(8'd0, 10'd0, 1'b1);        // lost line after positive error
    send_pixel(8'd0, 10'd0, 1'b1);        // lost line with zero error
    send_pixel(8'd200, 10'd0, 1'b1);      // left of center, negative error
    send_pixel(8'd128, 10'd500, 1'b1);    // level equal to threshold is dark, spin after neg
    send_pixel(8'd129, 10'd161, 1'b0);    // sum -1 over 3: truncates to zero
    send_pixel(8'd129, 10'd160, 1'b0);
    send_pixel(8'd129, 10'd158, 1'b1);
    send_pixel(8'd255, 10'd165, 1'b0);
    send_pixel(8'd255, 10'd167, 1'b1);
    send_pixel(8'd200, 10'd300, 1'b0);    // dark pixel closes a frame with a line
    send_pixel(8'd10, 10'd0, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: ;
        1: begin
          // max gains, threshold 0: positive sum saturates
          load_settings(0, 0, 65535, 65535, 65535, 255, 255);
          write_reg(REG_NONE, 16'hFFFF);
          send_bright_run(SAT_RUN, 1023);
        end
        2: load_settings(255, 1023, 0, 0, 0, -255, 0);   // nothing can be white
        3: begin
          load_settings(0, 1023, 4096, 8192, 4096, -100, 128);
          send_bright_run(SAT_RUN, 0);                   // negative sum saturation
        end
        default: load_settings($urandom_range(16, 240), $urandom_range(0, 1023),
                               $urandom_range(0, 16384), $urandom_range(0, 16384),
                               $urandom_range(0, 1024), $urandom_range(0, 510) - 255,
                               $urandom_range(0, 255));
      endcase
      pix_gaps_on = (phase % 3) != 1;
      res_stalls_on = (phase % 4) != 2;
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < PIXEL_GOAL / PHASES)
        send_random_frame();
    end

    settle();
    $display("summary: %0d pixel items, %0d register writes, %0d phases", pixels_sent,
             writes_done, PHASES);
    $display("summary: %0d steering items checked, %0d of them with the line lost",
             results_seen, lost_results);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d frames unanswered", fail_count, pending);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lcps_pkg.sv
rtl/core/lcps_front.sv
rtl/core/lcps_queue.sv
rtl/core/lcps_back.sv
rtl/core/line_centroid_pid_steering.sv
rtl/core/lcps_checker.sv
tb/lcps_checker.sv
tb/tb_top.sv
